// ----- sv/smm_pkg.sv -----
// Shared types, constants and helpers for the square matrix multiply core.
// Depends on nothing; every other source file but smm_ram imports it.
`default_nettype none

package smm_pkg;

  // Matrix geometry
  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int ORD_W     = 4;

  // Arithmetic widths
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 35;

  // Stream widths
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int IN_PAD_W   = IN_DATA_W - (2 * IDX_W + VAL_W);
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * IDX_W + ACC_W);

  localparam logic [ORD_W-1:0] ORDER_RST = ORD_W'(MAX_ORDER);
  localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(MAX_ORDER - 1);

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_NONE    = 2'd3
  } smm_kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } smm_state_t;

  // Tag that follows each pair of store reads down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             lastall;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } smm_tag_t;

  // Status from the MAC pipeline back to the sequencer
  typedef struct packed {
    logic adv;
    logic final_done;
  } smm_stat_t;

  // Order register to last index (n-1); 0 acts as 1, above MAX_ORDER as MAX_ORDER
  function automatic logic [IDX_W-1:0] order_last(input logic [ORD_W-1:0] ord);
    logic [ORD_W-1:0] dec;
    dec = ord - ORD_W'(1);
    if (ord == '0) begin
      return '0;
    end else if (ord > ORD_W'(MAX_ORDER)) begin
      return IDX_MAX;
    end else begin
      return dec[IDX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/smm_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module smm_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port; holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/smm_seq.sv -----
// Sequencer: accepts input beats, writes loads into the stores, and walks
// i/j/k to issue store reads for a compute. Uses smm_pkg.
`default_nettype none

module smm_seq
  import smm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [IDX_W-1:0]      in_row,
  input  wire logic [IDX_W-1:0]      in_col,
  input  wire logic [ORD_W-1:0]      order,
  input  wire smm_stat_t             stat,
  output logic                       a_we,
  output logic                       b_we,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [ADDR_W-1:0]          a_raddr,
  output logic [ADDR_W-1:0]          b_raddr,
  output smm_tag_t                   tag
);

  smm_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] nm1_r, nm1_nxt;
  logic             accept;
  logic             start;
  logic             issue;
  logic             k_end, j_end, i_end;

  assign k_end = (k_r == nm1_r);
  assign j_end = (j_r == nm1_r);
  assign i_end = (i_r == nm1_r);

  // output decode
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    accept    = in_tvalid && in_tready;
    a_we      = accept && (smm_kind_t'(in_kind) == KIND_LOAD_A);
    b_we      = accept && (smm_kind_t'(in_kind) == KIND_LOAD_B);
    start     = accept && (smm_kind_t'(in_kind) == KIND_COMPUTE);
    issue     = (state_r == ST_ISSUE) && stat.adv;
  end

  assign wr_addr = {in_row, in_col};
  assign a_raddr = {i_r, k_r};
  assign b_raddr = {k_r, j_r};

  // tag for the read issued this cycle
  always_comb begin
    tag.valid   = (state_r == ST_ISSUE);
    tag.first   = (k_r == '0);
    tag.lastk   = k_end;
    tag.lastall = k_end && j_end && i_end;
    tag.i       = i_r;
    tag.j       = j_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue && tag.lastall) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.final_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // index counters, k innermost
  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    nm1_nxt = nm1_r;
    if (start) begin
      i_nxt   = '0;
      j_nxt   = '0;
      k_nxt   = '0;
      nm1_nxt = order_last(order);
    end else if (issue) begin
      if (k_end) begin
        k_nxt = '0;
        if (j_end) begin
          j_nxt = '0;
          i_nxt = i_end ? '0 : i_r + IDX_W'(1);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      nm1_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      nm1_r   <= nm1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/smm_mac.sv -----
// Multiply-accumulate pipeline and result output register.
// Stages: store read, product register, accumulate into output. Uses smm_pkg.
`default_nettype none

module smm_mac
  import smm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smm_tag_t          tag,
  input  wire logic [VAL_W-1:0]  a_data,
  input  wire logic [VAL_W-1:0]  b_data,
  output smm_stat_t              stat,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [IDX_W-1:0]       out_row,
  output logic [IDX_W-1:0]       out_col,
  output logic [ACC_W-1:0]       out_value,
  output logic                   out_last
);

  smm_tag_t                 tag1_r, tag2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     adv;
  logic                     res_load;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic [ACC_W-1:0]         out_value_r;
  logic                     out_last_r;

  // whole pipeline moves unless a held result is blocked
  assign adv      = !out_valid_r || out_tready;
  assign res_load = tag2_r.valid && tag2_r.lastk;

  assign stat.adv        = adv;
  assign stat.final_done = adv && tag2_r.valid && tag2_r.lastall;

  // signed Q8.8 x Q8.8
  assign prod_nxt = $signed(a_data) * $signed(b_data);
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_sum  = tag2_r.first ? prod_ext : acc_r + prod_ext;

  // tags, product, accumulator; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      tag1_r      <= tag;
      tag2_r      <= tag1_r;
      out_valid_r <= res_load;
      prod_r      <= prod_nxt;
      if (tag2_r.valid) begin
        acc_r <= acc_sum;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv && res_load) begin
      out_row_r   <= tag2_r.i;
      out_col_r   <= tag2_r.j;
      out_value_r <= acc_sum;
      out_last_r  <= tag2_r.lastall;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- sv/square_matrix_multiply_core.sv -----
// Top level of the square matrix multiply core: stores, sequencer, MAC pipeline.
// Depends on smm_pkg, smm_ram, smm_seq, smm_mac.
//
// Computes C = A * B for signed Q8.8 matrices of order n (cfg_wdata, 1..8, reset 8;
// 0 acts as 1 and values above 8 as 8). A load beat (tuser kind 0 = A, 1 = B) writes
// one element at (row, col). A compute beat (kind 2) emits the n*n elements of C in
// row-major order as exact signed Q19.16 values, tlast on the final one; kind 3 is
// dropped. The core does one multiply-accumulate per cycle while the result register
// is not blocked, set by the single read port of each store and the one multiplier;
// each result element takes n of them.
// in_tready stays low from a compute beat until its last result sits in the output
// register. Elements must be loaded before they are used: there is no clearing pass.
`default_nettype none

module square_matrix_multiply_core
  import smm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration: matrix order
  input  wire logic                  cfg_we,
  input  wire logic [ORD_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // row[2:0], col[5:3], value[21:6]
  input  wire logic [KIND_W-1:0]     in_tuser,   // kind[1:0]
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_row[2:0], out_col[5:3],
                                                 // out_value[40:6]
  output logic                       out_tlast   // last
);

  logic [ORD_W-1:0]  order_r;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [VAL_W-1:0]  in_value;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
  logic [VAL_W-1:0]  a_rdata, b_rdata;
  smm_tag_t          tag;
  smm_stat_t         stat;
  logic [IDX_W-1:0]  out_row, out_col;
  logic [ACC_W-1:0]  out_value;

  // order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RST;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  // unpack input beat
  assign in_row   = in_tdata[IDX_W-1:0];
  assign in_col   = in_tdata[2*IDX_W-1:IDX_W];
  assign in_value = in_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

  smm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .order     (order_r),
    .stat      (stat),
    .a_we      (a_we),
    .b_we      (b_we),
    .wr_addr   (wr_addr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .tag       (tag)
  );

  // A store, row-major
  smm_ram #(.DATA_W(VAL_W), .ADDR_W(ADDR_W)) u_left_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (in_value),
    .re    (stat.adv),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // B store, row-major
  smm_ram #(.DATA_W(VAL_W), .ADDR_W(ADDR_W)) u_right_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (in_value),
    .re    (stat.adv),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  smm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (tag),
    .a_data     (a_rdata),
    .b_data     (b_rdata),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  // pack result beat
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule

`default_nettype wire

// ----- sv/smm_chk.sv -----
// Port-level checker for square_matrix_multiply_core, bound to the top level.
// Uses smm_pkg for widths.
`default_nettype none

module smm_chk
  import smm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // input stays closed while a compute still has results to come
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open during compute");

  // final element sits on the diagonal corner
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[IDX_W-1:0] == out_tdata[2*IDX_W-1:IDX_W])
    else $error("last beat off the diagonal");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind square_matrix_multiply_core smm_chk u_smm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- tb/tb_square_matrix_multiply_core.sv -----
// Self-checking bench for square_matrix_multiply_core: loads A/B elements, runs
// products under several orders and checks every C element against a local model.
// Depends on smm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_square_matrix_multiply_core;
  import smm_pkg::*;

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;

  // one input beat as planned by the stimulus
  typedef struct {
    smm_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mm_beat_t;

  // one element of C as it should leave the core
  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } c_elem_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [ORD_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // row[2:0], col[5:3], value[21:6]
  logic [KIND_W-1:0]     in_tuser   = '0;   // kind[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // out_row[2:0], out_col[5:3], out_value[40:6]
  logic                  out_tlast;

  square_matrix_multiply_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // model state: order register and both element stores
  logic [ORD_W-1:0]        order_q;
  logic signed [VAL_W-1:0] mat_a [DEPTH];
  logic signed [VAL_W-1:0] mat_b [DEPTH];
  c_elem_t                 c_pending [$];

  // stimulus bookkeeping
  mm_beat_t beat_q [$];
  mm_beat_t shuffle_buf [$];
  bit       a_loaded [DEPTH];
  bit       b_loaded [DEPTH];
  int       live_beats = 0;
  int       fail_count = 0;
  bit       drv_calm   = 1'b0;
  bit       mon_calm   = 1'b0;
  int       drv_gap    = 0;
  int       mon_hold   = 0;
  int       mon_wait;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #6000000;
    $display("timeout: %0d C elements still outstanding", c_pending.size());
    $display("Regression FAIL");
    $finish;
  end

  // 0 acts as 1, anything above MAX_ORDER as MAX_ORDER
  function automatic int eff_order(input logic [ORD_W-1:0] ord);
    if (ord == '0) return 1;
    if (ord > ORD_W'(MAX_ORDER)) return MAX_ORDER;
    return int'(ord);
  endfunction

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return VAL_W'($urandom_range(0, 511)) - 16'd256;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // builds a beat and records which store entries are now defined
  function automatic mm_beat_t beat_of(input smm_kind_t k, input int r, input int c,
                                       input logic [VAL_W-1:0] v);
    mm_beat_t b;
    b.kind  = k;
    b.row   = IDX_W'(r);
    b.col   = IDX_W'(c);
    b.value = v;
    if (k == KIND_LOAD_A) a_loaded[r * MAX_ORDER + c] = 1'b1;
    if (k == KIND_LOAD_B) b_loaded[r * MAX_ORDER + c] = 1'b1;
    return b;
  endfunction

  function automatic void push_beat(input mm_beat_t b);
    beat_q.push_back(b);
    if (b.kind != KIND_NONE) live_beats++;
  endfunction

  // C = A * B for the active order, row-major, exact sums
  task automatic predict_product();
    int      n;
    longint  acc;
    c_elem_t e;
    n = eff_order(order_q);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(mat_a[i * MAX_ORDER + k]) * longint'(mat_b[k * MAX_ORDER + j]);
        end
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = acc[ACC_W-1:0];
        e.last  = (i == n - 1) && (j == n - 1);
        c_pending.push_back(e);
      end
    end
  endtask

  // one well-formed sequence: loads covering the n x n corner in random order,
  // a little noise, then usually a compute
  task automatic plan_product(input int n);
    mm_beat_t tmp;
    int       j;
    shuffle_buf.delete();
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!a_loaded[r * MAX_ORDER + c] || $urandom_range(0, 3) == 0)
          shuffle_buf.push_back(beat_of(KIND_LOAD_A, r, c, draw_value()));
        if (!b_loaded[r * MAX_ORDER + c] || $urandom_range(0, 3) == 0)
          shuffle_buf.push_back(beat_of(KIND_LOAD_B, r, c, draw_value()));
      end
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: shuffle_buf.push_back(beat_of(KIND_NONE, $urandom_range(0, 7),
                                         $urandom_range(0, 7), VAL_W'($urandom)));
        1: shuffle_buf.push_back(beat_of(KIND_LOAD_A, $urandom_range(0, 7),
                                         $urandom_range(0, 7), draw_value()));
        default: shuffle_buf.push_back(beat_of(KIND_LOAD_B, $urandom_range(0, 7),
                                               $urandom_range(0, 7), draw_value()));
      endcase
    end
    for (int i = shuffle_buf.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffle_buf[i];
      shuffle_buf[i] = shuffle_buf[j];
      shuffle_buf[j] = tmp;
    end
    foreach (shuffle_buf[i]) push_beat(shuffle_buf[i]);
    // now and then a sequence is cut off before its compute
    if ($urandom_range(0, 9) != 0) push_beat(beat_of(KIND_COMPUTE, 0, 0, '0));
  endtask

  // wait until every beat is sent and every C element has come back
  task automatic wait_idle();
    while (beat_q.size() != 0 || in_tvalid || c_pending.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORD_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // model of the order register
  always @(posedge clk) begin
    if (!rst_n) begin
      order_q <= ORDER_RST;
    end else if (cfg_we) begin
      order_q <= cfg_wdata;
    end
  end

  // input driver; each accepted beat also updates the model
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      drv_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        case (smm_kind_t'(in_tuser))
          KIND_LOAD_A: mat_a[in_tdata[IDX_W-1:0] * MAX_ORDER + in_tdata[2*IDX_W-1:IDX_W]]
                         = in_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
          KIND_LOAD_B: mat_b[in_tdata[IDX_W-1:0] * MAX_ORDER + in_tdata[2*IDX_W-1:IDX_W]]
                         = in_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
          KIND_COMPUTE: predict_product();
          default: ;
        endcase
      end
      // bus slot free after this edge
      if (!in_tvalid || in_tready) begin
        if (drv_gap != 0) begin
          in_tvalid <= 1'b0;
          drv_gap   <= drv_gap - 1;
        end else if (beat_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= beat_q[0].kind;
          in_tdata  <= {{IN_PAD_W{1'b0}}, beat_q[0].value, beat_q[0].col, beat_q[0].row};
          drv_gap   <= draw_wait(drv_calm);
          void'(beat_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : c_monitor
    c_elem_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mon_hold   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (c_pending.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected C beat: row %0d col %0d value %h last %b",
                     out_tdata[IDX_W-1:0], out_tdata[2*IDX_W-1:IDX_W],
                     out_tdata[2*IDX_W+ACC_W-1:2*IDX_W], out_tlast);
        end else begin
          want = c_pending.pop_front();
          if (out_tdata[IDX_W-1:0] !== want.row || out_tdata[2*IDX_W-1:IDX_W] !== want.col ||
              out_tdata[2*IDX_W+ACC_W-1:2*IDX_W] !== want.value || out_tlast !== want.last)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("C mismatch: exp row %0d col %0d value %h last %b, got row %0d col %0d value %h last %b",
                       want.row, want.col, want.value, want.last,
                       out_tdata[IDX_W-1:0], out_tdata[2*IDX_W-1:IDX_W],
                       out_tdata[2*IDX_W+ACC_W-1:2*IDX_W], out_tlast);
          end
        end
        mon_wait = draw_wait(mon_calm);
        if (mon_wait != 0) begin
          out_tready <= 1'b0;
          mon_hold   <= mon_wait - 1;
        end else begin
          out_tready <= 1'b1;
        end
      end else if (mon_hold != 0) begin
        out_tready <= 1'b0;
        mon_hold   <= mon_hold - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus: directed phases, then random phases under changing orders
  initial begin : stimulus
    logic [ORD_W-1:0] ord;
    int               phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // order 2: extreme values, a load outside the active corner, an unused kind
    write_order(ORD_W'(2));
    push_beat(beat_of(KIND_LOAD_A, 0, 0, 16'h8000));
    push_beat(beat_of(KIND_LOAD_A, 0, 1, 16'h8000));
    push_beat(beat_of(KIND_LOAD_A, 1, 0, 16'h7fff));
    push_beat(beat_of(KIND_LOAD_A, 1, 1, 16'h8000));
    push_beat(beat_of(KIND_LOAD_B, 0, 0, 16'h8000));
    push_beat(beat_of(KIND_LOAD_B, 0, 1, 16'h7fff));
    push_beat(beat_of(KIND_LOAD_B, 1, 0, 16'h8000));
    push_beat(beat_of(KIND_LOAD_B, 1, 1, 16'h8000));
    push_beat(beat_of(KIND_LOAD_A, 7, 7, 16'h7fff));
    push_beat(beat_of(KIND_LOAD_B, 7, 0, 16'h0001));
    push_beat(beat_of(KIND_NONE, 7, 7, 16'hffff));
    push_beat(beat_of(KIND_COMPUTE, 0, 0, '0));
    wait_idle();

    // order 0 behaves as order 1
    write_order('0);
    push_beat(beat_of(KIND_COMPUTE, 0, 0, '0));
    wait_idle();

    // order 1 with opposite extremes
    write_order(ORD_W'(1));
    push_beat(beat_of(KIND_LOAD_A, 0, 0, 16'h7fff));
    push_beat(beat_of(KIND_LOAD_B, 0, 0, 16'h8000));
    push_beat(beat_of(KIND_COMPUTE, 0, 0, '0));
    wait_idle();

    // random phases; the first two hit the full order and an oversized one
    phase = 0;
    while (live_beats < 460) begin
      case (phase)
        0: ord = ORD_W'(MAX_ORDER);
        1: ord = 4'hf;
        default: begin
          case ($urandom_range(0, 9))
            0:       ord = '0;
            1:       ord = ORD_W'($urandom_range(9, 15));
            2, 3:    ord = ORD_W'($urandom_range(5, 8));
            default: ord = ORD_W'($urandom_range(1, 4));
          endcase
        end
      endcase
      write_order(ord);
      drv_calm = ($urandom_range(0, 3) == 0);
      mon_calm = ($urandom_range(0, 3) == 0);
      repeat ((eff_order(ord) > 4) ? 1 : $urandom_range(1, 3)) plan_product(eff_order(ord));
      wait_idle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && c_pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/smm_pkg.sv
sv/smm_ram.sv
sv/smm_seq.sv
sv/smm_mac.sv
sv/square_matrix_multiply_core.sv
sv/smm_chk.sv
tb/tb_square_matrix_multiply_core.sv
